[src/npcm_pkg.sv]
package npcm_pkg;

   localparam int PalSize = 16;

   typedef logic [3:0] pal_index_type;
   typedef logic [7:0] score_type;
   typedef logic [9:0] dist_type;
   typedef logic [6:0] symbol_type;
   typedef logic [23:0] pixel_type;

   typedef score_type [PalSize-1:0] score_vec_type;

   // candidate carried through the minimum tree
   typedef struct packed {
      score_type     score;
      pal_index_type index;
   } cand_type;

   localparam logic [7:0] PalRed [PalSize] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd192,
      8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255
   };
   localparam logic [7:0] PalGreen [PalSize] = '{
      8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd192,
      8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255
   };
   localparam logic [7:0] PalBlue [PalSize] = '{
      8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd192,
      8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255
   };
   // 'x' '@' '-' '+' '$' '%' '^' '&' '*' ';' '/' ' ' '?' '#' '~' '.'
   localparam symbol_type SymTable [PalSize] = '{
      7'd120, 7'd64, 7'd45, 7'd43, 7'd36, 7'd37, 7'd94, 7'd38,
      7'd42, 7'd59, 7'd47, 7'd32, 7'd63, 7'd35, 7'd126, 7'd46
   };

   // floor(x/3) for x <= 765: 683/2048 overshoots by under 1/8
   localparam logic [9:0] RecipThree = 10'd683;
   localparam int RecipShift = 11;

endpackage

[src/npcm_dist.sv]
module npcm_dist (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  npcm_pkg::pixel_type     in_pixel,
   output logic                    out_valid,
   output npcm_pkg::score_vec_type out_scores
);
   import npcm_pkg::*;

   logic      sum_valid_ff, sum_valid_in;
   dist_type  sum_ff [PalSize];
   dist_type  sum_in [PalSize];
   logic      score_valid_ff, score_valid_in;
   score_vec_type score_ff, score_in;

   logic [7:0] red, green, blue;

   function automatic dist_type abs_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] d;
      d = (a >= b) ? (a - b) : (b - a);
      return {2'b00, d};
   endfunction

   assign red   = in_pixel[23:16];
   assign green = in_pixel[15:8];
   assign blue  = in_pixel[7:0];

   // sum the channel distances to each palette entry
   always_comb begin
      for (int i = 0; i < PalSize; i++) begin
         sum_in[i] = abs_diff(red, PalRed[i]) + abs_diff(green, PalGreen[i])
                   + abs_diff(blue, PalBlue[i]);
      end
      sum_valid_in = in_valid;
   end

   // scale each sum by the reciprocal of three
   always_comb begin
      logic [19:0] prod;
      prod = '0;
      for (int i = 0; i < PalSize; i++) begin
         prod        = {10'd0, sum_ff[i]} * {10'd0, RecipThree};
         score_in[i] = prod[RecipShift +: 8];
      end
      score_valid_in = sum_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff   <= 1'b0;
         score_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff   <= sum_valid_in;
         score_valid_ff <= score_valid_in;
      end
   end

   // payload carries no reset
   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      score_ff <= score_in;
   end

   assign out_valid  = score_valid_ff;
   assign out_scores = score_ff;

endmodule

[src/npcm_min.sv]
module npcm_min (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  npcm_pkg::score_vec_type in_scores,
   output logic                    out_valid,
   output npcm_pkg::pal_index_type out_index,
   output npcm_pkg::symbol_type    out_symbol
);
   import npcm_pkg::*;

   localparam int Quads = PalSize / 4;

   logic       quad_valid_ff, quad_valid_in;
   cand_type   quad_ff [Quads];
   cand_type   quad_in [Quads];
   logic       res_valid_ff, res_valid_in;
   pal_index_type res_index_ff, res_index_in;
   symbol_type res_symbol_ff, res_symbol_in;

   // keep the lower-index candidate unless the other is strictly smaller
   function automatic cand_type pick(input cand_type lo, input cand_type hi);
      return (hi.score < lo.score) ? hi : lo;
   endfunction

   // reduce each group of four to its best entry
   always_comb begin
      cand_type c0, c1, c2, c3;
      c0 = '0;
      c1 = '0;
      c2 = '0;
      c3 = '0;
      for (int q = 0; q < Quads; q++) begin
         c0 = '{score: in_scores[4*q],   index: pal_index_type'(4*q)};
         c1 = '{score: in_scores[4*q+1], index: pal_index_type'(4*q+1)};
         c2 = '{score: in_scores[4*q+2], index: pal_index_type'(4*q+2)};
         c3 = '{score: in_scores[4*q+3], index: pal_index_type'(4*q+3)};
         quad_in[q] = pick(pick(c0, c1), pick(c2, c3));
      end
      quad_valid_in = in_valid;
   end

   // reduce the four group winners and look up the symbol
   always_comb begin
      cand_type best;
      best          = pick(pick(quad_ff[0], quad_ff[1]), pick(quad_ff[2], quad_ff[3]));
      res_index_in  = best.index;
      res_symbol_in = SymTable[best.index];
      res_valid_in  = quad_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
         res_valid_ff  <= 1'b0;
      end else begin
         quad_valid_ff <= quad_valid_in;
         res_valid_ff  <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quad_ff       <= quad_in;
      res_index_ff  <= res_index_in;
      res_symbol_ff <= res_symbol_in;
   end

   assign out_valid  = res_valid_ff;
   assign out_index  = res_index_ff;
   assign out_symbol = res_symbol_ff;

endmodule

[src/nearest_palette_char_mapper_top.sv]
// Maps each 24-bit pixel (red 23..16, green 15..8, blue 7..0) to the nearest
// of 16 fixed palette colours by floor(Manhattan distance / 3), lowest index
// on ties, and returns that index with its ASCII symbol. One pixel is taken
// every clock (busy stays low); the result appears on the rsp_ ports with
// rsp_valid high for one cycle, in request order. The result passes through
// four pipeline stages: distance sums, divide by three, first half of the
// minimum tree, second half plus symbol lookup. The receiver cannot stall,
// so results must be taken as they come.
module nearest_palette_char_mapper_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  npcm_pkg::pixel_type     req_rgb_pixel,
   output logic                    rsp_valid,
   output npcm_pkg::pal_index_type rsp_palette_index,
   output npcm_pkg::symbol_type    rsp_symbol_code
);
   import npcm_pkg::*;

   logic          score_valid;
   score_vec_type scores;

   // never hold off a request
   assign busy = 1'b0;

   npcm_dist u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (start),
      .in_pixel   (req_rgb_pixel),
      .out_valid  (score_valid),
      .out_scores (scores)
   );

   npcm_min u_min (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (score_valid),
      .in_scores  (scores),
      .out_valid  (rsp_valid),
      .out_index  (rsp_palette_index),
      .out_symbol (rsp_symbol_code)
   );

endmodule

[src/npcm_checker.sv]
module npcm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input npcm_pkg::pixel_type     req_rgb_pixel,
   input logic                    rsp_valid,
   input npcm_pkg::pal_index_type rsp_palette_index,
   input npcm_pkg::symbol_type    rsp_symbol_code
);
   import npcm_pkg::*;

   // every taken request yields a result on rsp_valid
   a_latency_hit: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("request without result after four cycles");

   // no result without a matching earlier request
   a_latency_miss: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##4 !rsp_valid)
      else $error("result without matching request");

   // symbol follows the chosen index
   a_symbol_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol_code == SymTable[rsp_palette_index]))
      else $error("symbol does not match palette index");

   // black lands on entry zero
   a_black: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_rgb_pixel == '0) |-> ##4 (rsp_palette_index == '0))
      else $error("black pixel not mapped to entry zero");

endmodule

bind nearest_palette_char_mapper_top npcm_checker u_npcm_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_rgb_pixel     (req_rgb_pixel),
   .rsp_valid         (rsp_valid),
   .rsp_palette_index (rsp_palette_index),
   .rsp_symbol_code   (rsp_symbol_code)
);
